FILE: rtl/fpp_pkg.sv
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared types and constants of the flash erase / program planner.
// ----------------------------------------------------------------------------
package fpp_pkg;

  // fixed field widths
  localparam int unsigned AddrW   = 24;
  localparam int unsigned PosW    = 25;
  localparam int unsigned OpW     = 8;
  localparam int unsigned CountW  = 9;
  localparam int unsigned ActionW = 2;

  // default geometry
  localparam int unsigned SectorBytesDef = 4096;
  localparam int unsigned BlockBytesDef  = 65536;
  localparam int unsigned PageBytesDef   = 256;

  // longest job: the whole 24-bit address space
  localparam logic [PosW-1:0] LenLimit = PosW'(1) << AddrW;

  // action codes, any other code is a next request
  localparam logic [ActionW-1:0] ActErase   = 2'd0;
  localparam logic [ActionW-1:0] ActProgram = 2'd1;
  localparam logic [ActionW-1:0] ActNext    = 2'd2;

  // flash opcodes
  localparam logic [OpW-1:0] OpNone         = 8'h00;
  localparam logic [OpW-1:0] OpSectorErase  = 8'h20;
  localparam logic [OpW-1:0] OpBlockErase   = 8'hd8;
  localparam logic [OpW-1:0] OpPageProgram  = 8'h02;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ERASE   = 2'd1,
    MODE_PROGRAM = 2'd2
  } mode_e;

  // request held in the input register, length already saturated and, for erase, rounded
  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [AddrW-1:0]   start_addr;
    logic [PosW-1:0]    len;
  } req_t;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [AddrW-1:0]  cmd_address;
    logic [CountW-1:0] byte_count;
    logic              last_command;
    logic              idle;
  } cmd_t;

  function automatic logic is_start(logic [ActionW-1:0] action);
    return action inside {ActErase, ActProgram};
  endfunction

endpackage

FILE: rtl/flash_erase_program_planner.sv
// ----------------------------------------------------------------------------
// flash_erase_program_planner
// Requests are held in the input register, commands in the result register.
// Throughput: one request per cycle unless the sink stalls; the two registers
// decouple stalls. Each command is planned combinationally from job position and end.
// Reset: asynchronous, active low; no job active, both registers empty.
// ----------------------------------------------------------------------------
module flash_erase_program_planner #(
  parameter int unsigned SECTOR_BYTES = fpp_pkg::SectorBytesDef,
  parameter int unsigned BLOCK_BYTES  = fpp_pkg::BlockBytesDef,
  parameter int unsigned PAGE_BYTES   = fpp_pkg::PageBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // start_addr[23:0], length[48:24], zero pad
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // opcode[7:0], cmd_address[31:8], byte_count[40:32]
  output logic        m_axis_tlast,   // last_command
  output logic        m_axis_tuser    // idle
);
  import fpp_pkg::*;

  logic req_valid, req_take, cmd_ready;
  req_t req;
  cmd_t cmd_plan, cmd_out;

  fpp_in_reg #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .action_i     (s_axis_tuser),
    .start_addr_i (s_axis_tdata[23:0]),
    .length_i     (s_axis_tdata[48:24]),
    .req_valid_o  (req_valid),
    .req_take_i   (req_take),
    .req_o        (req)
  );

  assign req_take = req_valid && cmd_ready;

  fpp_cmd_gen #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .BLOCK_BYTES  (BLOCK_BYTES),
    .PAGE_BYTES   (PAGE_BYTES)
  ) u_cmd_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (req_take),
    .req_i  (req),
    .cmd_o  (cmd_plan)
  );

  fpp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (req_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd_plan),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd_out)
  );

  assign m_axis_tdata = {7'd0, cmd_out.byte_count, cmd_out.cmd_address, cmd_out.opcode};
  assign m_axis_tlast = cmd_out.last_command;
  assign m_axis_tuser = cmd_out.idle;

endmodule

FILE: rtl/fpp_in_reg.sv
// ----------------------------------------------------------------------------
// fpp_in_reg
// Input register: captures a request, saturates its length and rounds erase
// lengths up to a whole sector.
// ----------------------------------------------------------------------------
module fpp_in_reg #(
  parameter int unsigned SECTOR_BYTES = fpp_pkg::SectorBytesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [fpp_pkg::ActionW-1:0] action_i,
  input  logic [fpp_pkg::AddrW-1:0]  start_addr_i,
  input  logic [fpp_pkg::PosW-1:0]   length_i,
  output logic                       req_valid_o,
  input  logic                       req_take_i,
  output fpp_pkg::req_t              req_o
);
  import fpp_pkg::*;

  localparam logic [PosW-1:0] SectorMask = PosW'(SECTOR_BYTES - 1);

  logic          valid_q, valid_d;
  req_t          req_q;
  logic [PosW-1:0] len_sat, len_eff;
  logic          load;

  assign in_ready_o = !valid_q || req_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    len_sat = (length_i > LenLimit) ? LenLimit : length_i;
    if (action_i == ActErase) begin
      len_eff = (len_sat + SectorMask) & ~SectorMask;
    end else begin
      len_eff = len_sat;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (req_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q.action     <= action_i;
      req_q.start_addr <= start_addr_i;
      req_q.len        <= len_eff;
    end
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

FILE: rtl/fpp_cmd_gen.sv
// ----------------------------------------------------------------------------
// fpp_cmd_gen
// Job state and command planning: picks the next erase or program command
// from position and end, and advances the position when a request is taken.
// ----------------------------------------------------------------------------
module fpp_cmd_gen #(
  parameter int unsigned SECTOR_BYTES = fpp_pkg::SectorBytesDef,
  parameter int unsigned BLOCK_BYTES  = fpp_pkg::BlockBytesDef,
  parameter int unsigned PAGE_BYTES   = fpp_pkg::PageBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  fpp_pkg::req_t req_i,
  output fpp_pkg::cmd_t cmd_o
);
  import fpp_pkg::*;

  localparam int unsigned BlockLog = $clog2(BLOCK_BYTES);
  localparam int unsigned PageLog  = $clog2(PAGE_BYTES);
  localparam logic [PosW-1:0] SectorLen = PosW'(SECTOR_BYTES);
  localparam logic [PosW-1:0] BlockLen  = PosW'(BLOCK_BYTES);
  localparam logic [PosW-1:0] PageLen   = PosW'(PAGE_BYTES);

  logic [PosW-1:0] pos_q, pos_d, end_q, end_d;
  mode_e           mode_q, mode_d;

  logic            start;
  mode_e           mode_cur;
  logic [PosW-1:0] pos_cur, end_cur, remain, step_raw, step;
  logic            last;
  logic [OpW-1:0]  op;

  assign start = is_start(req_i.action);

  always_comb begin
    if (start) begin
      pos_cur = PosW'(req_i.start_addr);
      end_cur = PosW'(req_i.start_addr) + req_i.len;
      remain  = req_i.len;
      if (req_i.len == '0) begin
        mode_cur = MODE_IDLE;
      end else if (req_i.action == ActErase) begin
        mode_cur = MODE_ERASE;
      end else begin
        mode_cur = MODE_PROGRAM;
      end
    end else begin
      pos_cur  = pos_q;
      end_cur  = end_q;
      remain   = end_q - pos_q;
      mode_cur = mode_q;
    end
  end

  // command size before clipping to what remains
  always_comb begin
    case (mode_cur)
      MODE_ERASE: begin
        if (pos_cur[BlockLog-1:0] == '0 && remain >= BlockLen) begin
          op       = OpBlockErase;
          step_raw = BlockLen;
        end else begin
          op       = OpSectorErase;
          step_raw = SectorLen;
        end
      end
      MODE_PROGRAM: begin
        op       = OpPageProgram;
        step_raw = PageLen - PosW'(pos_cur[PageLog-1:0]);
      end
      default: begin
        op       = OpNone;
        step_raw = '0;
      end
    endcase
  end

  assign step = (step_raw > remain) ? remain : step_raw;
  assign last = (step == remain);

  always_comb begin
    cmd_o = '0;
    if (mode_cur == MODE_IDLE) begin
      cmd_o.idle = 1'b1;
    end else begin
      cmd_o.opcode       = op;
      cmd_o.cmd_address  = pos_cur[AddrW-1:0];
      cmd_o.byte_count   = (mode_cur == MODE_PROGRAM) ? step[CountW-1:0] : '0;
      cmd_o.last_command = last;
    end
  end

  always_comb begin
    pos_d  = pos_q;
    end_d  = end_q;
    mode_d = mode_q;
    if (take_i) begin
      end_d = end_cur;
      if (mode_cur == MODE_IDLE) begin
        pos_d  = pos_cur;
        mode_d = MODE_IDLE;
      end else begin
        pos_d  = pos_cur + step;
        mode_d = last ? MODE_IDLE : mode_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      end_q  <= '0;
      mode_q <= MODE_IDLE;
    end else begin
      pos_q  <= pos_d;
      end_q  <= end_d;
      mode_q <= mode_d;
    end
  end

endmodule

FILE: rtl/fpp_out_reg.sv
// ----------------------------------------------------------------------------
// fpp_out_reg
// Result register: holds one planned command until the sink takes it.
// ----------------------------------------------------------------------------
module fpp_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  fpp_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fpp_pkg::cmd_t cmd_o
);
  import fpp_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q;
  logic load;

  assign cmd_ready_o = !valid_q || out_ready_i;
  assign load        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_i;
    end
  end

  assign out_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for flash_erase_program_planner. A clocked driver sends
// erase, program and next requests from a queue with random gaps. A clocked
// monitor stalls at random and compares every command with the plan that the
// bench works out itself from the job position and end.
// ----------------------------------------------------------------------------
module tb_top;
  import fpp_pkg::*;

  localparam logic [ActionW-1:0] ActNextAlt = 2'd3;  // code 3 also means next
  localparam int unsigned NumReqs = 1450;

  typedef struct {
    logic [ActionW-1:0] action;
    logic [AddrW-1:0]   start_addr;
    logic [PosW-1:0]    len;
  } flash_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;  // start_addr[23:0], length[48:24], zero pad
  logic [1:0]  s_axis_tuser = '0;  // action[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // opcode[7:0], cmd_address[31:8], byte_count[40:32]
  logic        m_axis_tlast;       // last_command
  logic        m_axis_tuser;       // idle

  flash_req_t pending_reqs[$];
  cmd_t       planned_cmds[$];
  flash_req_t cur_req;

  // planner state kept by the bench
  logic [PosW-1:0] job_pos;
  logic [PosW-1:0] job_end;
  mode_e           job_mode;

  int unsigned accepted_reqs;
  int unsigned seen_cmds;
  int unsigned error_count;
  int unsigned tx_wait;
  int unsigned rx_wait;
  logic        offer;
  logic        hold_off = 1'b0;

  flash_erase_program_planner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic cmd_t plan_command(input flash_req_t req);
    logic [PosW-1:0] len;
    logic [PosW-1:0] remain;
    logic [PosW-1:0] step;
    cmd_t            cmd;
    cmd = '0;
    if (!req.action[1]) begin
      len = (req.len > LenLimit) ? LenLimit : req.len;
      if (req.action == ActErase) begin
        len = (len + PosW'(SectorBytesDef - 1)) & ~PosW'(SectorBytesDef - 1);
        job_mode = MODE_ERASE;
      end else begin
        job_mode = MODE_PROGRAM;
      end
      job_pos = {1'b0, req.start_addr};
      job_end = job_pos + len;
      if (len == '0) job_mode = MODE_IDLE;
    end
    if (job_mode == MODE_IDLE || job_pos == job_end) begin
      job_mode = MODE_IDLE;
      cmd.idle = 1'b1;
      return cmd;
    end
    remain = job_end - job_pos;
    if (job_mode == MODE_ERASE) begin
      if ((job_pos & PosW'(BlockBytesDef - 1)) == '0 && remain >= PosW'(BlockBytesDef)) begin
        cmd.opcode = OpBlockErase;
        step = PosW'(BlockBytesDef);
      end else begin
        cmd.opcode = OpSectorErase;
        step = PosW'(SectorBytesDef);
      end
      if (step > remain) step = remain;
    end else begin
      step = PosW'(PageBytesDef) - (job_pos & PosW'(PageBytesDef - 1));
      if (step > remain) step = remain;
      cmd.opcode = OpPageProgram;
      cmd.byte_count = step[CountW-1:0];
    end
    cmd.cmd_address = job_pos[AddrW-1:0];
    job_pos = job_pos + step;
    cmd.last_command = (job_pos == job_end);
    if (cmd.last_command) job_mode = MODE_IDLE;
    return cmd;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] command %0d: %s got %0h expected %0h", $realtime, seen_cmds, what,
             got, want);
    error_count++;
  endtask

  task automatic add_req(input logic [ActionW-1:0] action, input logic [AddrW-1:0] addr,
                         input logic [PosW-1:0] len);
    flash_req_t req;
    req.action = action;
    req.start_addr = addr;
    req.len = len;
    pending_reqs.push_back(req);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_wait = $urandom_range(0, 10);
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        planned_cmds.push_back(plan_command(cur_req));
        accepted_reqs++;
        offer = 1'b0;
        // some stretches run with no gaps at all
        tx_wait = (accepted_reqs % 256 < 48) ? 0 : $urandom_range(0, 10);
      end
      if (!offer) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          offer = 1'b1;
          s_axis_tdata <= {7'b0, cur_req.len, cur_req.start_addr};
          s_axis_tuser <= cur_req.action;
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  // command monitor
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (planned_cmds.size() == 0) begin
          report_mismatch("unexpected command", m_axis_tdata[31:0], 0);
        end else begin
          want = planned_cmds.pop_front();
          if (m_axis_tdata[7:0] != want.opcode)
            report_mismatch("opcode", 32'(m_axis_tdata[7:0]), 32'(want.opcode));
          if (m_axis_tdata[31:8] != want.cmd_address)
            report_mismatch("cmd_address", 32'(m_axis_tdata[31:8]),
                            32'(want.cmd_address));
          if (m_axis_tdata[40:32] != want.byte_count)
            report_mismatch("byte_count", 32'(m_axis_tdata[40:32]),
                            32'(want.byte_count));
          if (m_axis_tlast != want.last_command)
            report_mismatch("last_command", 32'(m_axis_tlast), 32'(want.last_command));
          if (m_axis_tuser != want.idle)
            report_mismatch("idle", 32'(m_axis_tuser), 32'(want.idle));
        end
        seen_cmds++;
        rx_wait = ((seen_cmds + 100) % 256 < 48) ? 0 : $urandom_range(0, 10);
      end
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // long receiver hold-offs so the block backs up into its input
  initial begin
    wait (accepted_reqs >= 100);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
    wait (accepted_reqs >= 800);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    logic [AddrW-1:0] addr;
    logic [PosW-1:0]  len;
    int unsigned      pick;
    int unsigned      n;

    job_pos = '0;
    job_end = '0;
    job_mode = MODE_IDLE;

    // directed part
    add_req(ActNext, 24'h0, 25'h0);                  // no job active
    add_req(ActNextAlt, 24'hffffff, 25'h1ffffff);
    add_req(ActErase, 24'h0, 25'h0);                 // zero length start
    add_req(ActProgram, 24'hffffff, 25'h0);
    add_req(ActErase, 24'h0, 25'h1);                 // rounds up to one sector
    add_req(ActErase, 24'h0, 25'h20000);             // two blocks
    add_req(ActNext, 24'h0, 25'h0);
    add_req(ActNext, 24'h0, 25'h0);                  // finished, idle again
    add_req(ActErase, 24'h00f000, 25'h11000);        // sector then block
    add_req(ActNext, 24'h0, 25'h0);
    add_req(ActProgram, 24'h0, 25'h100);             // one full page
    add_req(ActProgram, 24'hfffff0, 25'h20);         // address wraps past the top
    add_req(ActNext, 24'h0, 25'h0);
    add_req(ActProgram, 24'hffffff, 25'h1ffffff);    // length saturates
    add_req(ActNextAlt, 24'h0, 25'h0);
    add_req(ActErase, 24'hffffff, 25'h1ffffff);      // abandons the program job
    add_req(ActNext, 24'h0, 25'h0);
    add_req(ActErase, 24'h0, 25'h1000000);
    add_req(ActProgram, 24'h123456, 25'd1000);
    add_req(ActNext, 24'h0, 25'h0);
    add_req(ActErase, 24'h7ff000, 25'h1000);
    add_req(ActErase, 24'h010000, 25'h0ffff);

    // random part: mostly well-formed jobs, some noise
    while (pending_reqs.size() < NumReqs) begin
      pick = $urandom_range(0, 99);
      addr = 24'($urandom);
      if (pick < 12) begin
        add_req(ActionW'($urandom_range(0, 3)), addr, PosW'($urandom_range(0, 25'h1ffffff)));
      end else if (pick < 52) begin
        case ($urandom_range(0, 2))
          0: addr[15:0] = '0;
          1: addr[11:0] = '0;
          default: ;
        endcase
        case ($urandom_range(0, 9))
          0: len = PosW'($urandom_range(0, 25'h1ffffff));
          1, 2: len = PosW'($urandom_range(0, 25'h30000));
          default: len = PosW'($urandom_range(0, 25'h8000));
        endcase
        add_req(ActErase, addr, len);
        n = $urandom_range(0, 20);
        repeat (n) add_req(($urandom_range(0, 7) == 0) ? ActNextAlt : ActNext,
                           24'($urandom), PosW'($urandom));
      end else begin
        if ($urandom_range(0, 3) == 0) addr[7:0] = '0;
        len = ($urandom_range(0, 9) == 0) ? PosW'($urandom_range(0, 25'h1ffffff))
                                          : PosW'($urandom_range(0, 1500));
        add_req(ActProgram, addr, len);
        n = $urandom_range(0, 10);
        repeat (n) add_req(($urandom_range(0, 7) == 0) ? ActNextAlt : ActNext,
                           24'($urandom), PosW'($urandom));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (planned_cmds.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
